[src/acd_pkg.sv]
// Package for the asynchronous convergence detector.
// Holds the beat structs, operation codes and register indexes.
// It has no dependencies; the top level, the checker and the testbench use it.
package acd_pkg;

   // Operation codes of a request beat.
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_PARTIAL = 2'd1;
   localparam logic [1:0] OP_CANCEL  = 2'd2;
   localparam logic [1:0] OP_GLOBAL  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_NEIGHBORS = 2'd1;
   localparam logic [1:0] CSR_PARTNER   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [15:0] THRESHOLD_RESET = 16'd10;
   localparam logic [4:0]  NEIGHBORS_RESET = 5'd1;
   localparam logic [3:0]  PARTNER_RESET   = 4'd0;

   localparam logic [15:0] RUN_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic        local_converged;
      logic [3:0]  source_node;
      logic [30:0] iteration_number;
      logic        send_channel_free;
      logic        cancel_channel_free;
      logic        global_value;
   } req_type;

   typedef struct packed {
      logic        send_partial;
      logic        send_cancel;
      logic [3:0]  message_node;
      logic [30:0] message_iteration;
      logic        global_converged;
      logic        stable_local;
      logic [4:0]  neighbors_pending;
   } rsp_type;

endpackage

[src/async_convergence_detector_top.sv]
// Top level of the asynchronous convergence detector.
// Depends on acd_pkg for the beat types and on acd_ram for the iteration tables.
//
// Usage:
//   The req channel carries one event per beat: an iteration tick, a received
//   partial message, a received cancel or a received global flag. Each request
//   beat yields exactly one rsp beat with the message to emit, if any, and the
//   global, stable and pending state after the event.
//   The csr channel writes the threshold, neighbor count and partner node; it
//   is always ready and is meant to be used while no request is in flight.
//   Writing the neighbor count also reloads the pending count.
// Pipeline and throughput:
//   An accepted request beat passes through the work stage into the output
//   register. One beat per cycle is sustained while rsp_ready is high. The
//   per-source iteration tables sit in one RAM with a registered read; the read
//   is issued at acceptance and the update is written back from the work stage,
//   with the write forwarded to a read of the same entry in that cycle.
// Reset and stalls:
//   Reset clears all state and marks every table entry as holding its reset
//   value, so no clearing pass is needed. While a response is stalled, one more
//   request is taken if the work stage is empty, and then req_ready drops.
module async_convergence_detector_top #(
   parameter int NODES      = 16,
   parameter int ITER_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  acd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output acd_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data
);

   localparam int AW = $clog2(NODES);
   localparam int DW = 2 * ITER_WIDTH;

   // Configuration registers.
   logic [15:0] thr_ff, thr_in;
   logic [4:0]  nbr_ff, nbr_in;
   logic [3:0]  partner_ff, partner_in;

   // Scalar detector state.
   logic [15:0] run_ff, run_in;
   logic        stable_ff, stable_in;
   logic [4:0]  pending_ff, pending_in;
   logic        global_ff, global_in;
   logic        dest_valid_ff, dest_valid_in;
   logic [3:0]  target_node_ff, target_node_in;

   // Table entry valid bits; an entry not valid holds its reset value.
   logic [NODES-1:0] entry_valid_ff;

   // Work stage.
   logic             s1_valid_ff;
   acd_pkg::req_type s1_req_ff;
   logic [AW-1:0]    s1_idx_ff;
   logic             s1_src_ok_ff;

   // Output register.
   logic             rsp_valid_ff;
   acd_pkg::rsp_type rsp_data_ff, rsp_in;

   // Forwarding of a write that meets a read of the same entry.
   logic          fwd_ff, fwd_in;
   logic [DW-1:0] fwd_data_ff;

   // RAM ports.
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] wr_data, ram_q;

   logic          s1_fire, req_fire, csr_fire;
   logic [AW+3:0] src_wide;
   logic [AW-1:0] req_idx;
   logic          req_src_ok;

   logic [DW-1:0]                rd_word;
   logic signed [ITER_WIDTH-1:0] s_eff, c_eff, cur;
   logic [ITER_WIDTH+30:0]       iter_wide;
   logic [15:0]                  run_inc;
   logic [5:0]                   pend_up;

   // Handshakes.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   // Source decode into a table address.
   assign src_wide   = {{AW{1'b0}}, req_data.source_node};
   assign req_idx    = src_wide[AW-1:0];
   assign req_src_ok = src_wide < (AW + 4)'(NODES);

   // Hold the read address while the work stage is stalled.
   assign rd_addr = req_ready ? req_idx : s1_idx_ff;
   assign fwd_in  = wr_en && (s1_idx_ff == rd_addr);

   acd_ram #(
      .WIDTH(DW),
      .DEPTH(NODES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(s1_idx_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // Table entry as seen by the work stage: forwarded, then reset value if unwritten.
   assign rd_word = fwd_ff ? fwd_data_ff : ram_q;
   always_comb begin
      if (entry_valid_ff[s1_idx_ff]) begin
         s_eff = rd_word[DW-1:ITER_WIDTH];
         c_eff = rd_word[ITER_WIDTH-1:0];
      end else begin
         s_eff = '1;
         c_eff = '0;
      end
   end

   // Received iteration reduced to a non-negative table value.
   assign iter_wide = {{ITER_WIDTH{1'b0}}, s1_req_ff.iteration_number};
   assign cur       = {1'b0, iter_wide[ITER_WIDTH-2:0]};

   assign run_inc = (run_ff != acd_pkg::RUN_MAX) ? run_ff + 16'd1 : run_ff;
   assign pend_up = {1'b0, pending_ff} + 6'd1;

   // Event processing and configuration writes.
   always_comb begin
      thr_in         = thr_ff;
      nbr_in         = nbr_ff;
      partner_in     = partner_ff;
      run_in         = run_ff;
      stable_in      = stable_ff;
      pending_in     = pending_ff;
      global_in      = global_ff;
      dest_valid_in  = dest_valid_ff;
      target_node_in = target_node_ff;
      rsp_in         = '0;
      wr_en          = 1'b0;
      wr_data        = {s_eff, c_eff};

      if (s1_fire) begin
         unique case (s1_req_ff.operation)
            acd_pkg::OP_TICK: begin
               if (!stable_ff) begin
                  if (s1_req_ff.local_converged) begin
                     run_in = run_inc;
                     if (run_inc >= thr_ff) begin
                        stable_in = 1'b1;
                     end
                  end else begin
                     run_in = '0;
                  end
               end else if (!s1_req_ff.local_converged) begin
                  stable_in = 1'b0;
                  run_in    = '0;
                  if (dest_valid_ff && s1_req_ff.cancel_channel_free) begin
                     rsp_in.send_cancel       = 1'b1;
                     rsp_in.message_node      = target_node_ff;
                     rsp_in.message_iteration = s1_req_ff.iteration_number;
                  end
               end else if (pending_ff == 5'd0) begin
                  global_in = 1'b1;
               end else if (pending_ff == 5'd1) begin
                  target_node_in = partner_ff;
                  dest_valid_in  = 1'b1;
                  if (s1_req_ff.send_channel_free) begin
                     rsp_in.send_partial      = 1'b1;
                     rsp_in.message_node      = partner_ff;
                     rsp_in.message_iteration = s1_req_ff.iteration_number;
                  end
               end
            end
            acd_pkg::OP_PARTIAL: begin
               if (s1_src_ok_ff) begin
                  if (s_eff < c_eff && c_eff < cur && pending_ff != 5'd0) begin
                     pending_in = pending_ff - 5'd1;
                  end
                  if (s_eff < cur) begin
                     wr_en   = 1'b1;
                     wr_data = {cur, c_eff};
                  end
               end
            end
            acd_pkg::OP_CANCEL: begin
               if (s1_src_ok_ff) begin
                  if (c_eff < s_eff && s_eff < cur) begin
                     pending_in = (pend_up > {1'b0, nbr_ff}) ? nbr_ff : pend_up[4:0];
                     global_in  = 1'b0;
                  end
                  if (c_eff < cur) begin
                     wr_en   = 1'b1;
                     wr_data = {s_eff, cur};
                  end
               end
            end
            acd_pkg::OP_GLOBAL: begin
               global_in = s1_req_ff.global_value;
            end
            default: begin
            end
         endcase
      end

      rsp_in.global_converged  = global_in;
      rsp_in.stable_local      = stable_in;
      rsp_in.neighbors_pending = pending_in;

      if (csr_fire) begin
         unique case (csr_index)
            acd_pkg::CSR_THRESHOLD: thr_in = csr_data;
            acd_pkg::CSR_NEIGHBORS: begin
               nbr_in     = csr_data[4:0];
               pending_in = csr_data[4:0];
            end
            acd_pkg::CSR_PARTNER: partner_in = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= acd_pkg::THRESHOLD_RESET;
         nbr_ff         <= acd_pkg::NEIGHBORS_RESET;
         partner_ff     <= acd_pkg::PARTNER_RESET;
         run_ff         <= '0;
         stable_ff      <= 1'b0;
         pending_ff     <= acd_pkg::NEIGHBORS_RESET;
         global_ff      <= 1'b0;
         dest_valid_ff  <= 1'b0;
         target_node_ff <= '0;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_ff         <= 1'b0;
      end else begin
         thr_ff         <= thr_in;
         nbr_ff         <= nbr_in;
         partner_ff     <= partner_in;
         run_ff         <= run_in;
         stable_ff      <= stable_in;
         pending_ff     <= pending_in;
         global_ff      <= global_in;
         dest_valid_ff  <= dest_valid_in;
         target_node_ff <= target_node_in;
         fwd_ff         <= fwd_in;
         if (wr_en) begin
            entry_valid_ff[s1_idx_ff] <= 1'b1;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
      if (req_fire) begin
         s1_req_ff    <= req_data;
         s1_idx_ff    <= req_idx;
         s1_src_ok_ff <= req_src_ok;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/acd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no package is needed.
module acd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the entry being written
   // returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/acd_checker.sv]
// Port-level checks for the asynchronous convergence detector.
// Depends on acd_pkg; bound to async_convergence_detector_top below.
module acd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input acd_pkg::rsp_type rsp_data
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A partial message is only sent from stable local convergence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_partial |-> rsp_data.stable_local && !rsp_data.send_cancel)
      else $error("partial sent without stable convergence");

   // A cancel is only sent when stability has just been lost.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_cancel |-> !rsp_data.stable_local)
      else $error("cancel sent while stable");

   // Without a message the destination fields are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_partial && !rsp_data.send_cancel
      |-> rsp_data.message_node == 4'd0 && rsp_data.message_iteration == 31'd0)
      else $error("message fields set without a message");

endmodule

bind async_convergence_detector_top acd_checker u_acd_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

[verif/tb_async_convergence_detector_top.sv]
// Self-checking testbench for async_convergence_detector_top: directed and random event
// beats with random stalls on both channels, checked against a built-in state predictor.
// Depends on acd_pkg and on the RTL of the block; it reads no files.
module tb_async_convergence_detector_top;

   // Local names for the package types and codes.
   typedef acd_pkg::req_type req_type;
   typedef acd_pkg::rsp_type rsp_type;
   localparam logic [1:0]  OP_TICK         = acd_pkg::OP_TICK;
   localparam logic [1:0]  OP_PARTIAL      = acd_pkg::OP_PARTIAL;
   localparam logic [1:0]  OP_CANCEL       = acd_pkg::OP_CANCEL;
   localparam logic [1:0]  OP_GLOBAL       = acd_pkg::OP_GLOBAL;
   localparam logic [1:0]  CSR_THRESHOLD   = acd_pkg::CSR_THRESHOLD;
   localparam logic [1:0]  CSR_NEIGHBORS   = acd_pkg::CSR_NEIGHBORS;
   localparam logic [1:0]  CSR_PARTNER     = acd_pkg::CSR_PARTNER;
   localparam logic [15:0] THRESHOLD_RESET = acd_pkg::THRESHOLD_RESET;
   localparam logic [4:0]  NEIGHBORS_RESET = acd_pkg::NEIGHBORS_RESET;
   localparam logic [3:0]  PARTNER_RESET   = acd_pkg::PARTNER_RESET;
   localparam logic [15:0] RUN_MAX         = acd_pkg::RUN_MAX;

   localparam longint ITER_MAX = 64'h7FFF_FFFF;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Tracks the detector state and holds the status beats still expected back.
   class convergence_tracker;
      logic [15:0] threshold;
      logic [4:0]  neighbors;
      logic [3:0]  partner;
      logic [15:0] run_count;
      logic        stable_state;
      logic [4:0]  pending;
      logic        converged_all;
      logic        dest_valid;
      logic [3:0]  target_node;
      longint      sent_iter[16];
      longint      cancel_iter[16];
      rsp_type     expected_status[$];
      int unsigned errors;

      function new();
         threshold = THRESHOLD_RESET;
         neighbors = NEIGHBORS_RESET;
         partner = PARTNER_RESET;
         run_count = '0;
         stable_state = 1'b0;
         pending = NEIGHBORS_RESET;
         converged_all = 1'b0;
         dest_valid = 1'b0;
         target_node = '0;
         errors = 0;
         foreach (sent_iter[i]) begin
            sent_iter[i] = -1;
            cancel_iter[i] = 0;
         end
      endfunction

      function void write_register(logic [1:0] index, logic [15:0] data);
         case (index)
            CSR_THRESHOLD: threshold = data;
            CSR_NEIGHBORS: begin
               // The neighbor count also reloads the pending counter.
               neighbors = data[4:0];
               pending = data[4:0];
            end
            CSR_PARTNER: partner = data[3:0];
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return expected_status.size();
      endfunction

      // Applies one accepted event beat and queues the status it must produce.
      function void note_event(req_type ev);
         rsp_type want;
         longint  cur;
         longint  s;
         longint  c;
         want = '0;
         cur = longint'(ev.iteration_number);
         s = sent_iter[ev.source_node];
         c = cancel_iter[ev.source_node];
         case (ev.operation)
            OP_TICK: begin
               if (!stable_state) begin
                  if (ev.local_converged) begin
                     if (run_count < RUN_MAX) run_count = run_count + 1'b1;
                     if (run_count >= threshold) stable_state = 1'b1;
                  end else begin
                     run_count = '0;
                  end
               end else if (!ev.local_converged) begin
                  // Losing convergence cancels the last partial message if the channel is free.
                  stable_state = 1'b0;
                  run_count = '0;
                  if (dest_valid && ev.cancel_channel_free) begin
                     want.send_cancel = 1'b1;
                     want.message_node = target_node;
                     want.message_iteration = ev.iteration_number;
                  end
               end else if (pending == 0) begin
                  converged_all = 1'b1;
               end else if (pending == 1) begin
                  target_node = partner;
                  dest_valid = 1'b1;
                  if (ev.send_channel_free) begin
                     want.send_partial = 1'b1;
                     want.message_node = partner;
                     want.message_iteration = ev.iteration_number;
                  end
               end
            end
            OP_PARTIAL: begin
               if (s < c && c < cur && pending > 0) pending = pending - 1'b1;
               if (s < cur) sent_iter[ev.source_node] = cur;
            end
            OP_CANCEL: begin
               if (c < s && s < cur) begin
                  if (pending >= neighbors) pending = neighbors;
                  else pending = pending + 1'b1;
                  converged_all = 1'b0;
               end
               if (c < cur) cancel_iter[ev.source_node] = cur;
            end
            default: converged_all = ev.global_value;
         endcase
         want.global_converged = converged_all;
         want.stable_local = stable_state;
         want.neighbors_pending = pending;
         expected_status.push_back(want);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         end
      endfunction

      // Compares a status beat with the oldest expectation.
      function void check_status(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            errors++;
            $display("%0t: status beat with none expected, expected none, actual 0x%0h",
                     $time, got);
            return;
         end
         want = expected_status.pop_front();
         compare_field("send_partial", want.send_partial, got.send_partial);
         compare_field("send_cancel", want.send_cancel, got.send_cancel);
         compare_field("message_node", want.message_node, got.message_node);
         compare_field("message_iteration", want.message_iteration, got.message_iteration);
         compare_field("global_converged", want.global_converged, got.global_converged);
         compare_field("stable_local", want.stable_local, got.stable_local);
         compare_field("neighbors_pending", want.neighbors_pending, got.neighbors_pending);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_THRESHOLD;
   logic [15:0] csr_data = '0;

   convergence_tracker tracker = new();
   bit          in_idle = 1'b1;
   bit          out_idle = 1'b1;
   int unsigned cycle_count = 0;
   longint      msg_iter[16];
   bit          msg_sent[16];

   always #2 clock = ~clock;

   async_convergence_detector_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** async_convergence_detector_top: FAILED **");
         $finish;
      end
   end

   // Every status beat taken is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_status(rsp_data);
   end

   // Status side: a random stall before each beat in idling phases, none otherwise.
   initial begin
      int unsigned gap;
      forever begin
         gap = out_idle ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type make_event(logic [1:0] op, logic conv, logic [3:0] src,
                                          logic [30:0] iter, logic send_free,
                                          logic cancel_free, logic gval);
      req_type ev;
      ev.operation = op;
      ev.local_converged = conv;
      ev.source_node = src;
      ev.iteration_number = iter;
      ev.send_channel_free = send_free;
      ev.cancel_channel_free = cancel_free;
      ev.global_value = gval;
      return ev;
   endfunction

   // Mostly ticks and well-ordered partial/cancel pairs per source, plus stale
   // messages and global flags. Fields an operation ignores stay random.
   function automatic req_type next_random_event();
      logic [63:0] raw;
      req_type     ev;
      int unsigned pick;
      int unsigned src;
      longint      step;
      raw = {$urandom, $urandom};
      ev = raw[40:0];
      pick = $urandom_range(0, 99);
      src = $urandom_range(0, 15);
      if (pick < 45) begin
         ev.operation = OP_TICK;
         ev.local_converged = ($urandom_range(0, 9) != 0);
         ev.send_channel_free = ($urandom_range(0, 3) != 0);
         ev.cancel_channel_free = ($urandom_range(0, 3) != 0);
      end else if (pick < 82) begin
         step = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1 << 22) : $urandom_range(1, 16);
         if (msg_iter[src] + step > ITER_MAX) msg_iter[src] = ITER_MAX;
         else msg_iter[src] = msg_iter[src] + step;
         ev.operation = msg_sent[src] ? OP_CANCEL : OP_PARTIAL;
         msg_sent[src] = !msg_sent[src];
         ev.source_node = 4'(src);
         ev.iteration_number = 31'(msg_iter[src]);
      end else if (pick < 94) begin
         // Stale or repeated iteration: must be filtered by the tables.
         ev.operation = $urandom_range(0, 1) ? OP_CANCEL : OP_PARTIAL;
         ev.source_node = 4'(src);
         ev.iteration_number = 31'($urandom_range(0, 32'(msg_iter[src])));
      end else begin
         ev.operation = OP_GLOBAL;
      end
      return ev;
   endfunction

   // Offers one event beat, after a random gap in idling phases.
   task automatic send_event(req_type ev);
      int unsigned gap;
      gap = in_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (!req_ready);
      tracker.note_event(ev);
   endtask

   // Valid is left high between writes; the caller lowers it after the last one.
   task automatic write_csr(logic [1:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(index, data);
   endtask

   task automatic write_settings(logic [15:0] thr, logic [4:0] nb, logic [3:0] pt);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_NEIGHBORS, {11'd0, nb});
      write_csr(CSR_PARTNER, {12'd0, pt});
      csr_valid <= 1'b0;
   endtask

   // Stops offering events and waits until every status beat has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      req_type     directed_events[$];
      logic [15:0] thr;
      logic [4:0]  nb;
      logic [3:0]  pt;
      int unsigned count;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: threshold 2, two neighbors, partner at the top index.
      write_settings(16'd2, 5'd2, 4'd15);
      // Cancel with no partial sent before it.
      directed_events.push_back(make_event(OP_CANCEL, 1'b0, 4'd3, 31'd5, 1'b1, 1'b1, 1'b0));
      // Two converged ticks reach stability, at both iteration extremes.
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd0, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'h7FFF_FFFF,
                                           1'b1, 1'b1, 1'b1));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd3, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_PARTIAL, 1'b0, 4'd1, 31'd10, 1'b1, 1'b1, 1'b0));
      // One neighbor pending: send dropped on a busy channel, then sent.
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd11, 1'b0, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'h2AAA_AAAA,
                                           1'b1, 1'b1, 1'b0));
      // Loss of convergence with the cancel channel busy.
      directed_events.push_back(make_event(OP_TICK, 1'b0, 4'd0, 31'd13, 1'b1, 1'b0, 1'b0));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd14, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd15, 1'b0, 1'b1, 1'b0));
      // Loss with a free channel; the destination stays valid afterwards.
      directed_events.push_back(make_event(OP_TICK, 1'b0, 4'hF, 31'h5555_5555,
                                           1'b0, 1'b1, 1'b0));
      // Stale partial, then a cancel accepted and the same cancel repeated.
      directed_events.push_back(make_event(OP_PARTIAL, 1'b0, 4'd1, 31'd9, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_CANCEL, 1'b0, 4'd1, 31'd20, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_CANCEL, 1'b0, 4'd1, 31'd20, 1'b1, 1'b1, 1'b0));
      // Pending count down to zero, then one more partial against the floor.
      directed_events.push_back(make_event(OP_PARTIAL, 1'b0, 4'd2, 31'd30, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_PARTIAL, 1'b0, 4'd1, 31'd30, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_PARTIAL, 1'b1, 4'd4, 31'd40, 1'b1, 1'b1, 1'b1));
      // Stable again with nothing pending declares global convergence.
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd41, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd42, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_TICK, 1'b1, 4'd0, 31'd43, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_GLOBAL, 1'b0, 4'd0, 31'd0, 1'b0, 1'b0, 1'b0));
      directed_events.push_back(make_event(OP_GLOBAL, 1'b1, 4'hF, 31'h7FFF_FFFF,
                                           1'b1, 1'b1, 1'b1));
      // Cancels push the pending count up to the neighbor count and hold it there.
      directed_events.push_back(make_event(OP_CANCEL, 1'b0, 4'd2, 31'd50, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_CANCEL, 1'b0, 4'd1, 31'd50, 1'b1, 1'b1, 1'b0));
      directed_events.push_back(make_event(OP_CANCEL, 1'b0, 4'd4, 31'd50, 1'b1, 1'b1, 1'b0));
      foreach (directed_events[i]) send_event(directed_events[i]);
      wait_idle();

      // Random part: one setting per phase, extremes first.
      foreach (msg_iter[i]) begin
         msg_iter[i] = 100;
         msg_sent[i] = 1'b0;
      end
      for (int ph = 0; ph < 11; ph++) begin
         count = 52;
         case (ph)
            0: begin
               thr = 16'd1; nb = 5'd16; pt = 4'd0;
               in_idle = 1'b1; out_idle = 1'b1;
            end
            1: begin
               thr = 16'd0; nb = 5'd1; pt = 4'd15;
               in_idle = 1'b0; out_idle = 1'b0;
            end
            2: begin
               thr = 16'hFFFF; nb = 5'd3; pt = 4'd7; count = 20;
               in_idle = 1'b1; out_idle = 1'b0;
            end
            default: begin
               thr = 16'($urandom_range(1, 5));
               nb = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 4));
               pt = 4'($urandom_range(0, 15));
               in_idle = 1'($urandom_range(0, 1));
               out_idle = 1'($urandom_range(0, 1));
            end
         endcase
         write_settings(thr, nb, pt);
         repeat (count) send_event(next_random_event());
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("** async_convergence_detector_top: PASSED **");
      end else begin
         $display("** async_convergence_detector_top: FAILED **");
      end
      $finish;
   end
endmodule

[sim.f]
src/acd_pkg.sv
src/acd_ram.sv
src/async_convergence_detector_top.sv
src/acd_checker.sv
verif/tb_async_convergence_detector_top.sv
